/* rtl/core/baro_pkg.sv */
package baro_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CAL_W     = 16;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 15;
    localparam int PRES_W    = 17;

    // calibration register map
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SENS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TCS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TCO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TREF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMPSENS = 3'd5;

    localparam int C_TEMP_REF  = 2000;   // 20.00 C
    localparam int C_VLOW_OFS  = 3500;   // distance from 20.00 C down to -15.00 C
    localparam int C_TEMP_MIN  = -4000;
    localparam int C_TEMP_MAX  = 8500;
    localparam int C_PRES_MIN  = 1000;
    localparam int C_PRES_MAX  = 120000;

    // accept edge to result strobe
    localparam int LATENCY = 11;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] tcs;
        logic [CAL_W-1:0] tco;
        logic [CAL_W-1:0] tref;
        logic [CAL_W-1:0] tempsens;
    } t_cal;

    // first-order terms and squares, leaving the front stages
    typedef struct packed {
        logic               valid;
        logic [RAW_W-1:0]   d1;
        logic signed [18:0] temp;
        logic signed [34:0] off;
        logic signed [33:0] sens;
        logic [16:0]        t2;
        logic [33:0]        a;
        logic [34:0]        b;
        logic               low;
        logic               vlow;
    } t_front;

    // corrected terms, leaving the second-order stages
    typedef struct packed {
        logic               valid;
        logic [RAW_W-1:0]   d1;
        logic signed [19:0] tempc;
        logic signed [39:0] offc;
        logic signed [38:0] sensc;
    } t_corr;

endpackage

/* rtl/core/baro_cal_regs.sv */
module baro_cal_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [baro_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [baro_pkg::CAL_W-1:0]       i_cfg_wdata,
    output baro_pkg::t_cal                   o_cal
);
    import baro_pkg::*;

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAL_SENS:     r_cal.sens     <= i_cfg_wdata;
                REG_CAL_OFFSET:   r_cal.offset   <= i_cfg_wdata;
                REG_CAL_TCS:      r_cal.tcs      <= i_cfg_wdata;
                REG_CAL_TCO:      r_cal.tco      <= i_cfg_wdata;
                REG_CAL_TREF:     r_cal.tref     <= i_cfg_wdata;
                REG_CAL_TEMPSENS: r_cal.tempsens <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

/* rtl/core/baro_front.sv */
module baro_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [baro_pkg::RAW_W-1:0]    i_raw_pressure,
    input  logic [baro_pkg::RAW_W-1:0]    i_raw_temperature,
    input  baro_pkg::t_cal                i_cal,
    output baro_pkg::t_front              o_front
);
    import baro_pkg::*;

    // stage 1: dT
    logic signed [24:0] n1_dt;
    logic               r1_valid;
    logic [RAW_W-1:0]   r1_d1;
    logic signed [24:0] r1_dt;

    // stage 2: products of dT
    logic signed [41:0] n2_mt, n2_mo, n2_ms;
    logic signed [49:0] n2_sq;
    logic               r2_valid;
    logic [RAW_W-1:0]   r2_d1;
    logic signed [41:0] r2_mt, r2_mo, r2_ms;
    logic [47:0]        r2_sq;

    // stage 3: TEMP, OFF, SENS, T2
    logic signed [41:0] n3_qf, n3_of, n3_sf;
    logic signed [17:0] n3_q;
    logic signed [18:0] n3_temp;
    logic signed [34:0] n3_off;
    logic signed [33:0] n3_sens;
    logic               r3_valid;
    logic [RAW_W-1:0]   r3_d1;
    logic signed [17:0] r3_q;
    logic signed [18:0] r3_temp;
    logic signed [34:0] r3_off;
    logic signed [33:0] r3_sens;
    logic [16:0]        r3_t2;

    // stage 4: squares of the distances below the thresholds
    logic signed [18:0] n4_v;
    logic signed [35:0] n4_a;
    logic signed [37:0] n4_b;
    t_front             r4;

    assign n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.tref, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d1 <= i_raw_pressure;
        r1_dt <= n1_dt;
    end

    assign n2_mt = r1_dt * $signed({1'b0, i_cal.tempsens});
    assign n2_mo = r1_dt * $signed({1'b0, i_cal.tco});
    assign n2_ms = r1_dt * $signed({1'b0, i_cal.tcs});
    assign n2_sq = r1_dt * r1_dt;

    always_ff @(posedge i_clk) begin
        r2_d1 <= r1_d1;
        r2_mt <= n2_mt;
        r2_mo <= n2_mo;
        r2_ms <= n2_ms;
        r2_sq <= n2_sq[47:0];
    end

    // divide toward zero: bias negative values before the arithmetic shift
    assign n3_qf = (r2_mt + (r2_mt[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    assign n3_of = (r2_mo + (r2_mo[41] ? 42'sd127 : 42'sd0)) >>> 7;
    assign n3_sf = (r2_ms + (r2_ms[41] ? 42'sd255 : 42'sd0)) >>> 8;
    assign n3_q    = n3_qf[17:0];
    assign n3_temp = 19'(C_TEMP_REF) + 19'(n3_q);
    assign n3_off  = $signed({3'b000, i_cal.offset, 16'h0000}) + n3_of[34:0];
    assign n3_sens = $signed({3'b000, i_cal.sens, 15'h0000}) + n3_sf[33:0];

    always_ff @(posedge i_clk) begin
        r3_d1   <= r2_d1;
        r3_q    <= n3_q;
        r3_temp <= n3_temp;
        r3_off  <= n3_off;
        r3_sens <= n3_sens;
        r3_t2   <= r2_sq[47:31];
    end

    assign n4_v = 19'(r3_q) + 19'(C_VLOW_OFS);
    assign n4_a = r3_q * r3_q;
    assign n4_b = n4_v * n4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4.valid <= 1'b0;
        end else begin
            r4.valid <= r3_valid;
        end
        r4.d1   <= r3_d1;
        r4.temp <= r3_temp;
        r4.off  <= r3_off;
        r4.sens <= r3_sens;
        r4.t2   <= r3_t2;
        r4.a    <= n4_a[33:0];
        r4.b    <= n4_b[34:0];
        r4.low  <= r3_q[17];
        r4.vlow <= n4_v[18];
    end

    assign o_front = r4;

    a_vlow_implies_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4.valid && r4.vlow) |-> r4.low)
        else $error("below -15 C flagged without below 20 C");

    a_low_matches_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4.valid |-> (r4.low == (r4.temp < 19'(C_TEMP_REF))))
        else $error("second-order select disagrees with TEMP");

endmodule

/* rtl/core/baro_corr.sv */
module baro_corr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  baro_pkg::t_front   i_front,
    output baro_pkg::t_corr    o_corr
);
    import baro_pkg::*;

    // stage 5: OFF2, SENS2 and the corrected TEMP
    logic [36:0]        n5_a5;
    logic [37:0]        n5_b7;
    logic [38:0]        n5_b11;
    logic [39:0]        n5_off2;
    logic [39:0]        n5_sens2;
    logic signed [19:0] n5_tempc;
    logic               r5_valid;
    logic [RAW_W-1:0]   r5_d1;
    logic signed [19:0] r5_tempc;
    logic signed [34:0] r5_off;
    logic signed [33:0] r5_sens;
    logic [39:0]        r5_off2;
    logic [39:0]        r5_sens2;

    // stage 6: apply the corrections
    logic signed [40:0] n6_offc;
    logic signed [40:0] n6_sensc;
    t_corr              r6;

    assign n5_a5  = {1'b0, i_front.a, 2'b00} + {3'b000, i_front.a};
    assign n5_b7  = {i_front.b, 3'b000} - {3'b000, i_front.b};
    assign n5_b11 = {1'b0, i_front.b, 3'b000} + {3'b000, i_front.b, 1'b0}
                  + {4'b0000, i_front.b};

    always_comb begin
        n5_off2  = '0;
        n5_sens2 = '0;
        if (i_front.low) begin
            n5_off2  = {4'b0000, n5_a5[36:1]};
            n5_sens2 = {5'b00000, n5_a5[36:2]};
            if (i_front.vlow) begin
                n5_off2  = n5_off2 + {2'b00, n5_b7};
                n5_sens2 = n5_sens2 + {2'b00, n5_b11[38:1]};
            end
        end
    end

    assign n5_tempc = 20'(i_front.temp)
                    - $signed({3'b000, (i_front.low ? i_front.t2 : 17'd0)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= i_front.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_d1    <= i_front.d1;
        r5_tempc <= n5_tempc;
        r5_off   <= i_front.off;
        r5_sens  <= i_front.sens;
        r5_off2  <= n5_off2;
        r5_sens2 <= n5_sens2;
    end

    assign n6_offc  = 41'(r5_off) - $signed({1'b0, r5_off2});
    assign n6_sensc = 41'(r5_sens) - $signed({1'b0, r5_sens2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6.valid <= 1'b0;
        end else begin
            r6.valid <= r5_valid;
        end
        r6.d1    <= r5_d1;
        r6.tempc <= r5_tempc;
        r6.offc  <= n6_offc[39:0];
        r6.sensc <= n6_sensc[38:0];
    end

    assign o_corr = r6;

endmodule

/* rtl/core/baro_pres.sv */
module baro_pres (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  baro_pkg::t_corr                     i_corr,
    output logic                                o_strobe,
    output logic signed [baro_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic [baro_pkg::PRES_W-1:0]         o_pressure_pa,
    output logic                                o_clamped
);
    import baro_pkg::*;

    // stage 7: split D1 * SENS into two partial products
    logic [19:0]        n7_lo;
    logic signed [18:0] n7_hi;
    logic [43:0]        n7_plo;
    logic signed [43:0] n7_phi;
    logic               r7_valid;
    logic [43:0]        r7_plo;
    logic signed [43:0] r7_phi;
    logic signed [39:0] r7_offc;
    logic signed [19:0] r7_tempc;

    // stage 8: recombine
    logic signed [63:0] n8_prod;
    logic               r8_valid;
    logic signed [63:0] r8_prod;
    logic signed [39:0] r8_offc;
    logic signed [19:0] r8_tempc;

    // stage 9: scale by 2^-21
    logic signed [63:0] n9_yf;
    logic               r9_valid;
    logic signed [42:0] r9_y;
    logic signed [39:0] r9_offc;
    logic signed [19:0] r9_tempc;

    // stage 10: subtract OFF
    logic signed [43:0] n10_x;
    logic               r10_valid;
    logic signed [43:0] r10_x;
    logic signed [19:0] r10_tempc;

    // stage 11: scale by 2^-15, saturate
    logic signed [43:0]       n11_pf;
    logic signed [28:0]       n11_p;
    logic [PRES_W-1:0]        n11_pres;
    logic signed [TEMP_W-1:0] n11_temp;
    logic                     n11_pclip;
    logic                     n11_tclip;
    logic                     r_strobe;
    logic [PRES_W-1:0]        r_pres;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_clamped;

    assign n7_lo  = i_corr.sensc[19:0];
    assign n7_hi  = i_corr.sensc[38:20];
    assign n7_plo = i_corr.d1 * n7_lo;
    assign n7_phi = n7_hi * $signed({1'b0, i_corr.d1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r7_valid  <= i_corr.valid;
            r8_valid  <= r7_valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
            r_strobe  <= r10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_plo   <= n7_plo;
        r7_phi   <= n7_phi;
        r7_offc  <= i_corr.offc;
        r7_tempc <= i_corr.tempc;
    end

    assign n8_prod = (64'(r7_phi) <<< 20) + $signed({20'h00000, r7_plo});

    always_ff @(posedge i_clk) begin
        r8_prod  <= n8_prod;
        r8_offc  <= r7_offc;
        r8_tempc <= r7_tempc;
    end

    // divide toward zero
    assign n9_yf = (r8_prod + (r8_prod[63] ? 64'sd2097151 : 64'sd0)) >>> 21;

    always_ff @(posedge i_clk) begin
        r9_y     <= n9_yf[42:0];
        r9_offc  <= r8_offc;
        r9_tempc <= r8_tempc;
    end

    assign n10_x = 44'(r9_y) - 44'(r9_offc);

    always_ff @(posedge i_clk) begin
        r10_x     <= n10_x;
        r10_tempc <= r9_tempc;
    end

    assign n11_pf = (r10_x + (r10_x[43] ? 44'sd32767 : 44'sd0)) >>> 15;
    assign n11_p  = n11_pf[28:0];

    always_comb begin
        n11_pclip = 1'b1;
        if (n11_p < 29'(C_PRES_MIN)) begin
            n11_pres = PRES_W'(C_PRES_MIN);
        end else if (n11_p > 29'(C_PRES_MAX)) begin
            n11_pres = PRES_W'(C_PRES_MAX);
        end else begin
            n11_pres  = n11_p[PRES_W-1:0];
            n11_pclip = 1'b0;
        end
    end

    always_comb begin
        n11_tclip = 1'b1;
        if (r10_tempc < 20'(C_TEMP_MIN)) begin
            n11_temp = TEMP_W'(C_TEMP_MIN);
        end else if (r10_tempc > 20'(C_TEMP_MAX)) begin
            n11_temp = TEMP_W'(C_TEMP_MAX);
        end else begin
            n11_temp  = r10_tempc[TEMP_W-1:0];
            n11_tclip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pres    <= n11_pres;
        r_temp    <= n11_temp;
        r_clamped <= n11_pclip | n11_tclip;
    end

    assign o_strobe            = r_strobe;
    assign o_temperature_centi = r_temp;
    assign o_pressure_pa       = r_pres;
    assign o_clamped           = r_clamped;

endmodule

/* rtl/core/baro_temp_pressure_compensation_unit.sv */
// A result strobes on o_strobe once the word accepted for it has passed every pipeline stage.
// Throughput: one word per cycle while busy is low; each step of the 11-stage pipeline is
// one register stage with at most one multiplier on any path and short add chains before it.
// The receiver cannot stall; results are shown for exactly one cycle.
// Reset (synchronous, active low) clears the calibration words and all valid bits;
// busy is high during reset and the cycle after it, low otherwise.
module baro_temp_pressure_compensation_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [baro_pkg::RAW_W-1:0]          i_raw_pressure,
    input  logic [baro_pkg::RAW_W-1:0]          i_raw_temperature,
    input  logic                                i_cfg_we,
    input  logic [baro_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [baro_pkg::CAL_W-1:0]          i_cfg_wdata,
    output logic                                o_strobe,
    output logic signed [baro_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic [baro_pkg::PRES_W-1:0]         o_pressure_pa,
    output logic                                o_clamped
);
    import baro_pkg::*;

    logic   r_busy;
    logic   w_accept;
    t_cal   w_cal;
    t_front w_front;
    t_corr  w_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start & ~r_busy;

    baro_cal_regs u_cal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cal       (w_cal)
    );

    baro_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_accept),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cal             (w_cal),
        .o_front           (w_front)
    );

    baro_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (w_front),
        .o_corr  (w_corr)
    );

    baro_pres u_pres (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_corr              (w_corr),
        .o_strobe            (o_strobe),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .o_clamped           (o_clamped)
    );

    a_word_in_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept, LATENCY) |-> o_strobe)
        else $error("accepted word produced no result");

    a_temp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_temperature_centi >= TEMP_W'(C_TEMP_MIN)
                   && o_temperature_centi <= TEMP_W'(C_TEMP_MAX)))
        else $error("temperature outside saturation range");

    a_pres_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_pressure_pa >= PRES_W'(C_PRES_MIN)
                   && o_pressure_pa <= PRES_W'(C_PRES_MAX)))
        else $error("pressure outside saturation range");

endmodule
